### design/ttsp_pkg.sv
package ttsp_pkg;

  localparam int GRID_SIZE   = 64;
  localparam int PLANE_COUNT = 4;
  localparam int GRID_W      = $clog2(GRID_SIZE);
  localparam int PLANE_W     = $clog2(PLANE_COUNT);
  localparam int POS_W       = PLANE_W + 2 * GRID_W;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(PLANE_COUNT * GRID_SIZE * GRID_SIZE - 1);

  // attribute code boundaries
  localparam logic [15:0] CODE_END      = 16'd0;
  localparam logic [15:0] CODE_HEIGHT   = 16'd1;
  localparam logic [15:0] CODE_OVL_LAST = 16'd49;
  localparam logic [15:0] CODE_SET_LAST = 16'd81;
  localparam logic [5:0]  OVL_BASE      = 6'd2;
  localparam logic [5:0]  SET_BASE      = 6'd49;
  localparam logic [15:0] UND_BASE      = 16'd81;

  // result queue between parser and output stage
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [10:0] height;
    logic [3:0]         shape;
    logic [1:0]         turn;
    logic [15:0]        ovl_id;
    logic [5:0]         settings;
    logic [15:0]        underlay;
  } tile_rec_t;

  typedef struct packed {
    logic               is_summary;
    logic [POS_W-1:0]   pos;
    tile_rec_t          rec;
    logic               seen;
    logic signed [10:0] low;
    logic signed [10:0] high;
  } q_entry_t;

endpackage

### design/terrain_tile_stream_parser.sv
// terrain file parser: takes one byte per cycle while in_ready is high and reports each
// finished tile (plane, x, y order, y fastest) with its height, overlay, settings and
// underlay, then a summary with the height bounds after the byte flagged last_byte. parsing
// is done in the cycle a byte is accepted; results pass through a four-entry queue to a
// registered output, so out_valid can rise only once the causing byte's results have been
// written into the queue and then loaded into the output register. a byte may cause two
// results; in_ready is low while fewer than two queue slots are free, which only happens
// when the output side stalls. new_file restarts at tile zero and drops any unfinished file.
module terrain_tile_stream_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  input  logic               in_new_file,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_plane,
  output logic [5:0]         out_tile_x,
  output logic [5:0]         out_tile_y,
  output logic signed [10:0] out_height,
  output logic [3:0]         out_overlay_shape,
  output logic [1:0]         out_overlay_turn,
  output logic [15:0]        out_overlay_num,
  output logic [5:0]         out_settings,
  output logic [15:0]        out_underlay_num,
  output logic               out_is_summary,
  output logic signed [10:0] out_lowest_height,
  output logic signed [10:0] out_highest_height
);

  logic               in_accept;
  logic [1:0]         push_cnt;
  ttsp_pkg::q_entry_t push0, push1, head;
  logic               pop, not_empty, has_room;

  assign in_ready  = has_room;
  assign in_accept = in_valid && in_ready;

  ttsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .new_file  (in_new_file),
    .push_cnt  (push_cnt),
    .push0     (push0),
    .push1     (push1)
  );

  ttsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (push0),
    .push1     (push1),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .has_room  (has_room)
  );

  ttsp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .not_empty          (not_empty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_plane          (out_plane),
    .out_tile_x         (out_tile_x),
    .out_tile_y         (out_tile_y),
    .out_height         (out_height),
    .out_overlay_shape  (out_overlay_shape),
    .out_overlay_turn   (out_overlay_turn),
    .out_overlay_num    (out_overlay_num),
    .out_settings       (out_settings),
    .out_underlay_num   (out_underlay_num),
    .out_is_summary     (out_is_summary),
    .out_lowest_height  (out_lowest_height),
    .out_highest_height (out_highest_height)
  );

endmodule

### design/ttsp_front.sv
module ttsp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_accept,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic                new_file,
  output logic [1:0]          push_cnt,
  output ttsp_pkg::q_entry_t  push0,
  output ttsp_pkg::q_entry_t  push1
);

  localparam logic [2:0] PH_ATTR_HI = 3'd0;
  localparam logic [2:0] PH_ATTR_LO = 3'd1;
  localparam logic [2:0] PH_HEIGHT  = 3'd2;
  localparam logic [2:0] PH_OVL_HI  = 3'd3;
  localparam logic [2:0] PH_OVL_LO  = 3'd4;
  localparam logic [2:0] PH_ENDED   = 3'd5;

  logic [2:0]                    phase_r, phase_nxt;
  logic [ttsp_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic                          done_r, done_nxt;
  logic [7:0]                    held_r, held_nxt;
  ttsp_pkg::tile_rec_t           rec_r, rec_nxt;
  logic                          touched_r, touched_nxt;
  logic                          seen_r, seen_nxt;
  logic signed [10:0]            low_r, low_nxt;
  logic signed [10:0]            high_r, high_nxt;

  logic                          fin, part, summ;
  logic [ttsp_pkg::POS_W-1:0]    emit_pos;
  ttsp_pkg::tile_rec_t           emit_rec;
  logic [15:0]                   code;
  logic [5:0]                    ovl_off;
  logic signed [10:0]            h;
  ttsp_pkg::q_entry_t            tile_e, summ_e;

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    done_nxt    = done_r;
    held_nxt    = held_r;
    rec_nxt     = rec_r;
    touched_nxt = touched_r;
    seen_nxt    = seen_r;
    low_nxt     = low_r;
    high_nxt    = high_r;
    fin         = 1'b0;
    part        = 1'b0;
    summ        = 1'b0;
    h           = $signed({data_byte, 3'b000});

    // a new file starts from the reset state with this byte
    if (new_file) begin
      phase_nxt   = PH_ATTR_HI;
      pos_nxt     = '0;
      done_nxt    = 1'b0;
      held_nxt    = '0;
      rec_nxt     = '0;
      touched_nxt = 1'b0;
      seen_nxt    = 1'b0;
      low_nxt     = '0;
      high_nxt    = '0;
    end

    code     = {held_nxt, data_byte};
    ovl_off  = code[5:0] - ttsp_pkg::OVL_BASE;
    emit_pos = pos_nxt;
    emit_rec = rec_nxt;

    if (in_accept && phase_nxt != PH_ENDED) begin
      if (!done_nxt) begin
        unique case (phase_nxt)
          PH_ATTR_HI: begin
            held_nxt  = data_byte;
            phase_nxt = PH_ATTR_LO;
          end
          PH_ATTR_LO: begin
            phase_nxt = PH_ATTR_HI;
            if (code == ttsp_pkg::CODE_END) begin
              fin = 1'b1;
            end else if (code == ttsp_pkg::CODE_HEIGHT) begin
              phase_nxt = PH_HEIGHT;
            end else if (code <= ttsp_pkg::CODE_OVL_LAST) begin
              rec_nxt.shape = ovl_off[5:2];
              rec_nxt.turn  = ovl_off[1:0];
              touched_nxt   = 1'b1;
              phase_nxt     = PH_OVL_HI;
            end else if (code <= ttsp_pkg::CODE_SET_LAST) begin
              rec_nxt.settings = code[5:0] - ttsp_pkg::SET_BASE;
              touched_nxt      = 1'b1;
            end else begin
              rec_nxt.underlay = code - ttsp_pkg::UND_BASE;
              touched_nxt      = 1'b1;
            end
          end
          PH_HEIGHT: begin
            rec_nxt.height = h;
            if (!seen_nxt) begin
              low_nxt  = h;
              high_nxt = h;
              seen_nxt = 1'b1;
            end else begin
              if (h < low_nxt) low_nxt = h;
              if (h > high_nxt) high_nxt = h;
            end
            phase_nxt = PH_ATTR_HI;
            fin       = 1'b1;
          end
          PH_OVL_HI: begin
            held_nxt  = data_byte;
            phase_nxt = PH_OVL_LO;
          end
          PH_OVL_LO: begin
            rec_nxt.ovl_id = {held_nxt, data_byte};
            phase_nxt      = PH_ATTR_HI;
          end
          default: begin
          end
        endcase

        if (fin) begin
          emit_pos    = pos_nxt;
          emit_rec    = rec_nxt;
          rec_nxt     = '0;
          touched_nxt = 1'b0;
          if (pos_nxt == ttsp_pkg::POS_LAST) begin
            done_nxt = 1'b1;
          end else begin
            pos_nxt = pos_nxt + 1'b1;
          end
        end
      end

      if (last_byte) begin
        // unfinished tile goes out only if some attribute touched it
        if (!done_nxt && touched_nxt) begin
          part     = 1'b1;
          emit_pos = pos_nxt;
          emit_rec = rec_nxt;
        end
        summ      = 1'b1;
        phase_nxt = PH_ENDED;
      end
    end
  end

  always_comb begin
    tile_e            = '0;
    tile_e.is_summary = 1'b0;
    tile_e.pos        = emit_pos;
    tile_e.rec        = emit_rec;
    summ_e            = '0;
    summ_e.is_summary = 1'b1;
    summ_e.seen       = seen_nxt;
    summ_e.low        = low_nxt;
    summ_e.high       = high_nxt;
    push0    = (fin || part) ? tile_e : summ_e;
    push1    = summ_e;
    push_cnt = {1'b0, fin || part} + {1'b0, summ};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_ATTR_HI;
      pos_r     <= '0;
      done_r    <= 1'b0;
      held_r    <= '0;
      rec_r     <= '0;
      touched_r <= 1'b0;
      seen_r    <= 1'b0;
      low_r     <= '0;
      high_r    <= '0;
    end else if (in_accept) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      done_r    <= done_nxt;
      held_r    <= held_nxt;
      rec_r     <= rec_nxt;
      touched_r <= touched_nxt;
      seen_r    <= seen_nxt;
      low_r     <= low_nxt;
      high_r    <= high_nxt;
    end
  end

endmodule

### design/ttsp_queue.sv
module ttsp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_cnt,
  input  ttsp_pkg::q_entry_t  push0,
  input  ttsp_pkg::q_entry_t  push1,
  input  logic                pop,
  output ttsp_pkg::q_entry_t  head,
  output logic                not_empty,
  output logic                has_room
);

  ttsp_pkg::q_entry_t              mem [ttsp_pkg::QDEPTH];
  logic [ttsp_pkg::QPTR_W-1:0]     wr_r, wr_nxt;
  logic [ttsp_pkg::QPTR_W-1:0]     rd_r, rd_nxt;
  logic [ttsp_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic [ttsp_pkg::QPTR_W-1:0]     wr_second;

  assign head      = mem[rd_r];
  assign not_empty = (count_r != '0);
  // a byte can bring up to two results
  assign has_room  = (count_r <= ttsp_pkg::QCNT_W'(ttsp_pkg::QDEPTH - 2));
  assign wr_second = wr_r + 1'b1;

  always_comb begin
    wr_nxt    = wr_r + ttsp_pkg::QPTR_W'(push_cnt);
    rd_nxt    = rd_r + ttsp_pkg::QPTR_W'(pop);
    count_nxt = count_r + ttsp_pkg::QCNT_W'(push_cnt) - ttsp_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem[wr_r] <= push0;
    if (push_cnt == 2'd2) mem[wr_second] <= push1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### design/ttsp_back.sv
module ttsp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ttsp_pkg::q_entry_t  head,
  input  logic                not_empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_plane,
  output logic [5:0]          out_tile_x,
  output logic [5:0]          out_tile_y,
  output logic signed [10:0]  out_height,
  output logic [3:0]          out_overlay_shape,
  output logic [1:0]          out_overlay_turn,
  output logic [15:0]         out_overlay_num,
  output logic [5:0]          out_settings,
  output logic [15:0]         out_underlay_num,
  output logic                out_is_summary,
  output logic signed [10:0]  out_lowest_height,
  output logic signed [10:0]  out_highest_height
);

  localparam int X_LO = ttsp_pkg::GRID_W;
  localparam int P_LO = 2 * ttsp_pkg::GRID_W;

  logic               valid_r;
  logic [1:0]         plane_r;
  logic [5:0]         x_r, y_r;
  ttsp_pkg::tile_rec_t rec_r;
  logic               summ_r;
  logic signed [10:0] low_r, high_r;

  assign pop = not_empty && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      summ_r <= head.is_summary;
      if (head.is_summary) begin
        plane_r <= '0;
        x_r     <= '0;
        y_r     <= '0;
        rec_r   <= '0;
        low_r   <= head.seen ? head.low : 11'sd0;
        high_r  <= head.seen ? head.high : 11'sd0;
      end else begin
        plane_r <= 2'(head.pos[ttsp_pkg::POS_W-1:P_LO]);
        x_r     <= 6'(head.pos[P_LO-1:X_LO]);
        y_r     <= 6'(head.pos[X_LO-1:0]);
        rec_r   <= head.rec;
        low_r   <= '0;
        high_r  <= '0;
      end
    end
  end

  assign out_valid          = valid_r;
  assign out_plane          = plane_r;
  assign out_tile_x         = x_r;
  assign out_tile_y         = y_r;
  assign out_height         = rec_r.height;
  assign out_overlay_shape  = rec_r.shape;
  assign out_overlay_turn   = rec_r.turn;
  assign out_overlay_num    = rec_r.ovl_id;
  assign out_settings       = rec_r.settings;
  assign out_underlay_num   = rec_r.underlay;
  assign out_is_summary     = summ_r;
  assign out_lowest_height  = low_r;
  assign out_highest_height = high_r;

endmodule
